### rtl/core/ledv_pkg.sv
package ledv_pkg;

  localparam int FIELD_W = 32;
  localparam int TEMP_W  = 13;
  localparam int K_W     = 49;
  localparam int VEL_W   = 48;

  localparam logic [TEMP_W-1:0] T_NOM = 13'd1424;
  localparam logic [31:0] KNEE_R = 32'd16000;

  localparam logic [63:0] C_A0  = 64'd36149658;
  localparam logic [63:0] C_A1  = 64'd521253683;
  localparam logic [63:0] C_A2  = 64'd291008020;
  localparam logic [63:0] C_A3  = 64'd281149;
  localparam logic [63:0] C_A4  = 64'd2859336;
  localparam logic [63:0] C_A5  = 64'd13455;
  localparam logic [63:0] C_B   = 64'd944985;
  localparam logic [38:0] C_VEL = 39'd295147905179;
  localparam logic [46:0] VMAX  = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0][FIELD_W-1:0] mag;
  } lanes_t;

endpackage

### rtl/core/ledv_sqrt.sv
module ledv_sqrt #(
  parameter int IN_W  = 64,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_x,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [TAG_W-1:0]  out_tag
);
  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 3;
  localparam int ST    = RW + 1;

  logic [ST-1:0]    vld;
  logic [IN_W-1:0]  src   [ST];
  logic [REM_W-1:0] rem   [ST];
  logic [RW-1:0]    root  [ST];
  logic [TAG_W-1:0] tag   [ST];
  logic [REM_W-1:0] rem2  [RW];
  logic [REM_W-1:0] trial [RW];
  logic [RW-1:0]    ge;

  // one root bit per stage
  always_comb begin
    for (int i = 0; i < RW; i++) begin
      rem2[i]  = {rem[i][REM_W-3:0], src[i][IN_W-1 -: 2]};
      trial[i] = {1'b0, root[i], 2'b01};
      ge[i]    = rem2[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    src[0]  <= in_x;
    rem[0]  <= '0;
    root[0] <= '0;
    tag[0]  <= in_tag;
    for (int i = 0; i < RW; i++) begin
      src[i+1]  <= src[i] << 2;
      rem[i+1]  <= ge[i] ? (rem2[i] - trial[i]) : rem2[i];
      root[i+1] <= {root[i][RW-2:0], ge[i]};
      tag[i+1]  <= tag[i];
    end
  end

  assign out_valid = vld[ST-1];
  assign out_root  = root[ST-1];
  assign out_tag   = tag[ST-1];

endmodule

### rtl/core/ledv_div.sv
module ledv_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 32,
  parameter int Q_W   = 33,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0] out_tag
);
  localparam int ST = Q_W + 1;

  logic [ST-1:0]    vld;
  logic [Q_W-1:0]   src   [ST];
  logic [DEN_W-1:0] rem   [ST];
  logic [DEN_W-1:0] den   [ST];
  logic [Q_W-1:0]   quo   [ST];
  logic [TAG_W-1:0] tag   [ST];
  logic [DEN_W:0]   rem_s [Q_W];
  logic [DEN_W:0]   diff  [Q_W];
  logic [Q_W-1:0]   ge;

  // restoring division, one quotient bit per stage; the quotient is known to fit Q_W bits
  always_comb begin
    for (int i = 0; i < Q_W; i++) begin
      rem_s[i] = {rem[i], src[i][Q_W-1]};
      diff[i]  = rem_s[i] - {1'b0, den[i]};
      ge[i]    = rem_s[i] >= {1'b0, den[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    src[0] <= in_num[Q_W-1:0];
    rem[0] <= DEN_W'(in_num >> Q_W);
    den[0] <= in_den;
    quo[0] <= '0;
    tag[0] <= in_tag;
    for (int i = 0; i < Q_W; i++) begin
      src[i+1] <= src[i] << 1;
      rem[i+1] <= ge[i] ? diff[i][DEN_W-1:0] : rem_s[i][DEN_W-1:0];
      den[i+1] <= den[i];
      quo[i+1] <= {quo[i][Q_W-2:0], ge[i]};
      tag[i+1] <= tag[i];
    end
  end

  assign out_valid = vld[ST-1];
  assign out_quo   = quo[ST-1];
  assign out_tag   = tag[ST-1];

endmodule

### rtl/core/ledv_mul.sv
module ledv_mul #(
  parameter int A_W   = 32,
  parameter int B_W   = 32,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [A_W-1:0]     in_a,
  input  logic [B_W-1:0]     in_b,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_valid,
  output logic [A_W+B_W-1:0] out_prod,
  output logic [TAG_W-1:0]   out_tag
);
  localparam int AL  = A_W / 2;
  localparam int AH  = A_W - AL;
  localparam int BL  = B_W / 2;
  localparam int BH  = B_W - BL;
  localparam int P_W = A_W + B_W;

  logic [1:0]         vld;
  logic [AL+BL-1:0]   pll;
  logic [AL+BH-1:0]   plh;
  logic [AH+BL-1:0]   phl;
  logic [AH+BH-1:0]   phh;
  logic [TAG_W-1:0]   tag1;
  logic [P_W-1:0]     prod;
  logic [TAG_W-1:0]   tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[0], in_valid};
    end
  end

  // partial products, then their sum
  always_ff @(posedge clk) begin
    pll  <= (AL+BL)'(in_a[AL-1:0]) * (AL+BL)'(in_b[BL-1:0]);
    plh  <= (AL+BH)'(in_a[AL-1:0]) * (AL+BH)'(in_b[B_W-1:BL]);
    phl  <= (AH+BL)'(in_a[A_W-1:AL]) * (AH+BL)'(in_b[BL-1:0]);
    phh  <= (AH+BH)'(in_a[A_W-1:AL]) * (AH+BH)'(in_b[B_W-1:BL]);
    tag1 <= in_tag;
    prod <= P_W'(pll) + (P_W'(plh) << BL) + (P_W'(phl) << AL) + (P_W'(phh) << (AL + BL));
    tag2 <= tag1;
  end

  assign out_valid = vld[1];
  assign out_prod  = prod;
  assign out_tag   = tag2;

endmodule

### rtl/core/ledv_front.sv
module ledv_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   hold,
  output logic                   busy,
  input  logic [31:0]            field_x,
  input  logic [31:0]            field_y,
  input  logic [31:0]            field_z,
  output logic                   out_valid,
  output ledv_pkg::lanes_t       out_item
);
  import ledv_pkg::*;

  lanes_t     item;
  lanes_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // split each component into sign and magnitude
  always_comb begin
    item.neg = {field_z[31], field_y[31], field_x[31]};
    item.mag[0] = field_x[31] ? (~field_x + 32'd1) : field_x;
    item.mag[1] = field_y[31] ? (~field_y + 32'd1) : field_y;
    item.mag[2] = field_z[31] ? (~field_z + 32'd1) : field_z;
  end

  assign busy      = hold || (count == 2'd2);
  assign push      = start && !busy;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid;  // back end never stalls
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/core/ledv_temp.sv
module ledv_temp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ledv_pkg::TEMP_W-1:0] cfg_data,
  output logic                        busy,
  output logic [ledv_pkg::K_W-1:0]    k
);
  import ledv_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV1 = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DIV2 = 2'd3;

  logic [1:0]        state;
  logic [TEMP_W-1:0] tq;
  logic [59:0]       src;
  logic [TEMP_W-1:0] rem;
  logic [59:0]       quo;
  logic [29:0]       root;
  logic [31:0]       srem;
  logic [5:0]        cnt;
  logic [TEMP_W:0]   rem_s;
  logic              ge;
  logic [TEMP_W-1:0] rem_next;
  logic [59:0]       quo_next;
  logic [33:0]       srem2;
  logic [33:0]       strial;
  logic              sge;
  logic [29:0]       root_next;
  logic [40:0]       scaled;

  // shared serial divider by t and serial square root
  always_comb begin
    rem_s     = {rem, src[59]};
    ge        = rem_s >= {1'b0, tq};
    rem_next  = ge ? TEMP_W'(rem_s - {1'b0, tq}) : rem_s[TEMP_W-1:0];
    quo_next  = {quo[58:0], ge};
    srem2     = {srem, src[59:58]};
    strial    = {2'b00, root, 2'b01};
    sge       = srem2 >= strial;
    root_next = {root[28:0], sge};
    scaled    = 41'(T_NOM) * 41'(root_next);
  end

  assign cfg_ready = state == ST_IDLE;
  assign busy      = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= K_W'(64'h1_0000_0000);  // value at the reset temperature
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (cnt == 6'd59) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (cnt == 6'd29) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (cnt == 6'd59) begin
            state <= ST_IDLE;
            k     <= quo_next[K_W-1:0];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        tq   <= (cfg_data == '0) ? TEMP_W'(1) : cfg_data;
        src  <= 60'(T_NOM) << 48;
        rem  <= '0;
        quo  <= '0;
        cnt  <= '0;
      end
      ST_DIV1: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 6'd1;
        src <= src << 1;
        if (cnt == 6'd59) begin
          src  <= quo_next;
          srem <= '0;
          root <= '0;
          cnt  <= '0;
        end
      end
      ST_ROOT: begin
        srem <= 32'(sge ? (srem2 - strial) : srem2);
        root <= root_next;
        cnt  <= cnt + 6'd1;
        src  <= src << 2;
        if (cnt == 6'd29) begin
          src <= {11'd0, scaled, 8'd0};
          rem <= '0;
          quo <= '0;
          cnt <= '0;
        end
      end
      ST_DIV2: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 6'd1;
        src <= src << 1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

### rtl/core/ledv_back.sv
module ledv_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  ledv_pkg::lanes_t           in_item,
  input  logic [ledv_pkg::K_W-1:0]   k,
  output logic                       out_valid,
  output logic [ledv_pkg::VEL_W-1:0] vel_x,
  output logic [ledv_pkg::VEL_W-1:0] vel_y,
  output logic [ledv_pkg::VEL_W-1:0] vel_z
);
  import ledv_pkg::*;

  localparam int LW = $bits(lanes_t);

  function automatic logic [32:0] qm33(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b);
    return p[64:32];
  endfunction

  // squares
  logic        sq_v, sum_v;
  logic [63:0] sq [3];
  logic [63:0] sum;
  lanes_t      sq_l, sum_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v  <= 1'b0;
      sum_v <= 1'b0;
    end else begin
      sq_v  <= in_valid;
      sum_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= 64'(in_item.mag[i]) * 64'(in_item.mag[i]);
    end
    sq_l  <= in_item;
    sum   <= sq[0] + sq[1] + sq[2];
    sum_l <= sq_l;
  end

  // magnitude
  logic        r_v;
  logic [31:0] r;
  lanes_t      r_l;

  ledv_sqrt #(.IN_W(64), .TAG_W(LW)) u_sqrt_mag (
    .clk(clk), .rst(rst), .in_valid(sum_v), .in_x(sum), .in_tag(sum_l),
    .out_valid(r_v), .out_root(r), .out_tag(r_l)
  );

  // below the knee e = r/16000, above it g = 16000/r, both Q32
  logic        big;
  logic [45:0] d1_num;
  logic [31:0] d1_den;
  logic        x_v;
  logic [32:0] x;
  logic [LW:0] x_t;

  assign big    = r >= KNEE_R;
  assign d1_num = big ? (46'(KNEE_R) << 32) : (46'(r) << 32);
  assign d1_den = big ? r : KNEE_R;

  ledv_div #(.NUM_W(46), .DEN_W(32), .Q_W(33), .TAG_W(LW + 1)) u_div_field (
    .clk(clk), .rst(rst), .in_valid(r_v), .in_num(d1_num), .in_den(d1_den),
    .in_tag({big, r_l}), .out_valid(x_v), .out_quo(x), .out_tag(x_t)
  );

  logic           h_v;
  logic [31:0]    h_root;
  logic [LW+33:0] h_t;
  logic [32:0]    h;
  logic [32:0]    hx;
  logic           h_big;
  lanes_t         h_l;

  ledv_sqrt #(.IN_W(64), .TAG_W(LW + 34)) u_sqrt_half (
    .clk(clk), .rst(rst), .in_valid(x_v), .in_x({x[31:0], 32'd0}), .in_tag({x, x_t}),
    .out_valid(h_v), .out_root(h_root), .out_tag(h_t)
  );

  assign hx    = h_t[LW+33:LW+1];
  assign h_big = h_t[LW];
  assign h_l   = h_t[LW-1:0];
  assign h     = hx[32] ? 33'h1_0000_0000 : {1'b0, h_root};

  // powers of the field
  logic        p1_v, p2_v;
  logic [32:0] p1_x, p1_h, p1_x2, p1_x15;
  logic        p1_big;
  lanes_t      p1_l;
  logic [32:0] p2_x, p2_h, p2_x2, p2_x15, p2_x25, p2_x3;
  logic        p2_big;
  lanes_t      p2_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= h_v;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_x   <= hx;
    p1_h   <= h;
    p1_x2  <= qm33(hx, hx);
    p1_x15 <= qm33(hx, h);
    p1_big <= h_big;
    p1_l   <= h_l;
    p2_x   <= p1_x;
    p2_h   <= p1_h;
    p2_x2  <= p1_x2;
    p2_x15 <= p1_x15;
    p2_x25 <= qm33(p1_x2, p1_h);
    p2_x3  <= qm33(p1_x2, p1_x);
    p2_big <= p1_big;
    p2_l   <= p1_l;
  end

  // fit terms; above the knee both sums are divided by E^3
  logic        m_v, s_v;
  logic [63:0] tn [4];
  logic [63:0] td [4];
  lanes_t      m_l, s_l;
  logic [63:0] num, den;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      s_v <= 1'b0;
    end else begin
      m_v <= p2_v;
      s_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    tn[0] <= p2_big ? (C_A0 * 64'(p2_x3)) : (C_A0 << 32);
    tn[1] <= C_A1 * 64'(p2_big ? p2_x2 : p2_x);
    tn[2] <= C_A2 * 64'(p2_x15);
    tn[3] <= C_A3 * 64'(p2_big ? p2_h : p2_x25);
    td[0] <= p2_big ? (64'(p2_x3) << 16) : (64'd1 << 48);
    td[1] <= C_B * 64'(p2_big ? p2_x2 : p2_x);
    td[2] <= C_A4 * 64'(p2_big ? p2_x : p2_x2);
    td[3] <= p2_big ? (C_A5 << 32) : (C_A5 * 64'(p2_x3));
    m_l   <= p2_l;
    num   <= tn[0] + tn[1] + tn[2] + tn[3];
    den   <= td[0] + td[1] + td[2] + td[3];
    s_l   <= m_l;
  end

  // mobility, Q32
  logic        mu_v;
  logic [43:0] mu;
  lanes_t      mu_l;

  ledv_div #(.NUM_W(96), .DEN_W(64), .Q_W(44), .TAG_W(LW)) u_div_fit (
    .clk(clk), .rst(rst), .in_valid(s_v), .in_num({num, 32'd0}), .in_den(den),
    .in_tag(s_l), .out_valid(mu_v), .out_quo(mu), .out_tag(mu_l)
  );

  logic        t1_v;
  logic [92:0] t1_p;
  lanes_t      t1_l;

  ledv_mul #(.A_W(44), .B_W(K_W), .TAG_W(LW)) u_mul_temp (
    .clk(clk), .rst(rst), .in_valid(mu_v), .in_a(mu), .in_b(k), .in_tag(mu_l),
    .out_valid(t1_v), .out_prod(t1_p), .out_tag(t1_l)
  );

  logic        t2_v;
  logic [99:0] t2_p;
  lanes_t      t2_l;

  ledv_mul #(.A_W(61), .B_W(39), .TAG_W(LW)) u_mul_scale (
    .clk(clk), .rst(rst), .in_valid(t1_v), .in_a(t1_p[92:32]), .in_b(C_VEL),
    .in_tag(t1_l), .out_valid(t2_v), .out_prod(t2_p), .out_tag(t2_l)
  );

  // velocity per field unit, saturated to 64 bits
  logic        mv_v;
  logic [63:0] mv;
  lanes_t      mv_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv_v <= 1'b0;
    end else begin
      mv_v <= t2_v;
    end
  end

  always_ff @(posedge clk) begin
    mv   <= (t2_p[99:96] != 4'd0) ? '1 : t2_p[95:32];
    mv_l <= t2_l;
  end

  // per-component lanes
  logic [2:0]  ln_v;
  logic [95:0] ln_p [3];
  logic [2:0]  ln_neg;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ledv_mul #(.A_W(32), .B_W(64), .TAG_W(1)) u_mul_lane (
      .clk(clk), .rst(rst), .in_valid(mv_v), .in_a(mv_l.mag[i]), .in_b(mv),
      .in_tag(mv_l.neg[i]), .out_valid(ln_v[i]), .out_prod(ln_p[i]), .out_tag(ln_neg[i])
    );
  end

  logic [VEL_W-1:0] vel [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [96:0] full;
      logic [64:0] v;
      logic [VEL_W-1:0] mag;
      full = 97'(ln_p[i]) + 97'(32'h8000_0000);
      v    = full[96:32];
      mag  = {1'b0, (v > 65'(VMAX)) ? VMAX : v[46:0]};
      vel[i] = ln_neg[i] ? mag : (~mag + VEL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= &ln_v;
    end
  end

  always_ff @(posedge clk) begin
    vel_x <= vel[0];
    vel_y <= vel[1];
    vel_z <= vel[2];
  end

endmodule

### rtl/core/lar_electron_drift_velocity.sv
// Electron drift velocity in liquid argon from one field vector (1/16 V/cm units);
// results in 2^-40 cm/ns, rounded and saturated. Fully pipelined: one item per
// clock while busy is low; the path from start to done runs through the chain of
// bit-per-stage square roots and dividers. done pulses for one cycle with the
// velocity and cannot be held off; take it when it comes. A temperature write
// recomputes the scale factor in a serial unit, during which busy is high and
// cfg_ready is low; write it only while the block is idle.
module lar_electron_drift_velocity (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 field_x,
  input  logic [31:0]                 field_y,
  input  logic [31:0]                 field_z,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ledv_pkg::TEMP_W-1:0] cfg_data,
  output logic                        done,
  output logic [ledv_pkg::VEL_W-1:0]  velocity_x,
  output logic [ledv_pkg::VEL_W-1:0]  velocity_y,
  output logic [ledv_pkg::VEL_W-1:0]  velocity_z
);
  import ledv_pkg::*;

  logic           temp_busy;
  logic [K_W-1:0] k;
  logic           item_v;
  lanes_t         item;

  ledv_temp u_temp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .busy(temp_busy), .k(k)
  );

  ledv_front u_front (
    .clk(clk), .rst(rst), .start(start), .hold(temp_busy), .busy(busy),
    .field_x(field_x), .field_y(field_y), .field_z(field_z),
    .out_valid(item_v), .out_item(item)
  );

  ledv_back u_back (
    .clk(clk), .rst(rst), .in_valid(item_v), .in_item(item), .k(k),
    .out_valid(done), .vel_x(velocity_x), .vel_y(velocity_y), .vel_z(velocity_z)
  );

endmodule
